// File: sv/tap_pkg.sv
// ----------------------------------------------------------------------------
// tap_pkg
// shared constants of the triangle area and perimeter unit
// ----------------------------------------------------------------------------
package tap_pkg;

  // default coordinate width, signed q8.8
  localparam int unsigned CoordBitsDef = 16;

endpackage

// File: sv/tap_isqrt_pipe.sv
// ----------------------------------------------------------------------------
// tap_isqrt_pipe
// pipelined integer square root, one root bit resolved per register stage
// ----------------------------------------------------------------------------
module tap_isqrt_pipe #(
  parameter int unsigned COORD_BITS = tap_pkg::CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  en_i,    // advance all stages
  input  logic [2*COORD_BITS:0] rad_i,   // radicand
  output logic [COORD_BITS:0]   root_o   // floor of the square root
);

  localparam int unsigned K  = COORD_BITS + 1;  // root bits and stage count
  localparam int unsigned RW = 2 * K;           // padded radicand width
  localparam int unsigned MW = K + 3;           // partial remainder width

  logic [RW-1:0] rad_q  [K-1];
  logic [MW-1:0] rem_q  [K];
  logic [K-1:0]  root_q [K];

  for (genvar j = 0; j < K; j++) begin : g_stage
    logic [RW-1:0] src_rad;
    logic [MW-1:0] src_rem;
    logic [K-1:0]  src_root;
    logic [MW-1:0] cur;
    logic [MW-1:0] trial;
    logic [MW-1:0] rem_d;
    logic [K-1:0]  root_d;

    if (j == 0) begin : g_first
      assign src_rad  = {1'b0, rad_i};
      assign src_rem  = '0;
      assign src_root = '0;
    end else begin : g_next
      assign src_rad  = rad_q[j-1];
      assign src_rem  = rem_q[j-1];
      assign src_root = root_q[j-1];
    end

    // bring down the next two radicand bits and try root*4+1
    always_comb begin
      cur   = {src_rem[MW-3:0], src_rad[RW-1:RW-2]};
      trial = {1'b0, src_root, 2'b01};
      if (cur >= trial) begin
        rem_d  = cur - trial;
        root_d = {src_root[K-2:0], 1'b1};
      end else begin
        rem_d  = cur;
        root_d = {src_root[K-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        root_q[j] <= root_d;
      end
    end

    if (j < K - 1) begin : g_rad
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[j] <= {src_rad[RW-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[K-1];

endmodule

// File: sv/triangle_area_perimeter.sv
// ----------------------------------------------------------------------------
// triangle_area_perimeter
// shoelace area and floored-edge perimeter; with no output stall, one triangle per cycle
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one triangle per transfer: six signed coordinates of
//   COORD_BITS bits each (q8.8 by default). m_axis returns one result per
//   triangle, in order: the area in units of 2^-16 (truncated half of the
//   absolute shoelace cross sum) and the perimeter in q.8 units (sum of the
//   three floored edge lengths).
//   from an input transfer to the result on m_axis, a triangle passes one
//   stage of differences, one of multipliers, one of sums, COORD_BITS+1
//   stages of square root (one root bit per stage) and one stage of final add.
//   throughput is one triangle per cycle while the receiver is not stalling;
//   the square root pipeline depth sets the latency, not the rate.
//   reset clears every valid bit and the skid stage; no result is pending
//   after reset and s_axis_tready_o is high from reset on.
//   when the receiver stalls, the last result is caught in a skid register
//   and the whole pipeline holds until it is taken; s_axis_tready_o then
//   drops for exactly those cycles. nothing is lost or repeated.
// ----------------------------------------------------------------------------
module triangle_area_perimeter #(
  parameter int unsigned COORD_BITS = tap_pkg::CoordBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // ax, ay, bx, by, cx, cy from the lowest bit up, zero padded to bytes
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // area, perimeter from the lowest bit up, zero padded to bytes
  output logic [((3*COORD_BITS+4+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int unsigned N     = COORD_BITS;
  localparam int unsigned SQ    = 2 * N + 1;       // squared length sum
  localparam int unsigned PR    = 2 * N + 2;       // signed product
  localparam int unsigned CR    = 2 * N + 3;       // signed cross sum
  localparam int unsigned RT    = N + 1;           // edge length
  localparam int unsigned AW    = 2 * N + 1;       // area field
  localparam int unsigned PW    = N + 3;           // perimeter field
  localparam int unsigned L     = N + 5;           // pipeline stages
  localparam int unsigned OUT_W = ((3 * N + 4 + 7) / 8) * 8;

  // ---- flow control -------------------------------------------------------
  // the pipeline moves as one whenever the skid register is empty
  logic           en;
  logic           in_xfer;
  logic [L-1:0]   vld_q;
  logic           skid_vld_q;
  logic [OUT_W-1:0] skid_q;
  logic [OUT_W-1:0] res_data;

  assign en              = !skid_vld_q;
  assign s_axis_tready_o = en;
  assign in_xfer         = s_axis_tvalid_i && en;

  // ---- stage 1: coordinate differences ------------------------------------
  // edges ab, bc, ca, plus c-a for the cross product
  logic signed [N-1:0] crd [6];
  logic signed [N:0]   dx_d [3];
  logic signed [N:0]   dy_d [3];
  logic signed [N:0]   dx_q [3];
  logic signed [N:0]   dy_q [3];
  logic signed [N:0]   acx_d, acy_d, acx_q, acy_q;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      crd[i] = s_axis_tdata_i[i*N +: N];
    end
    dx_d[0] = {crd[2][N-1], crd[2]} - {crd[0][N-1], crd[0]};
    dy_d[0] = {crd[3][N-1], crd[3]} - {crd[1][N-1], crd[1]};
    dx_d[1] = {crd[4][N-1], crd[4]} - {crd[2][N-1], crd[2]};
    dy_d[1] = {crd[5][N-1], crd[5]} - {crd[3][N-1], crd[3]};
    dx_d[2] = {crd[0][N-1], crd[0]} - {crd[4][N-1], crd[4]};
    dy_d[2] = {crd[1][N-1], crd[1]} - {crd[5][N-1], crd[5]};
    acx_d   = {crd[4][N-1], crd[4]} - {crd[0][N-1], crd[0]};
    acy_d   = {crd[5][N-1], crd[5]} - {crd[1][N-1], crd[1]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      acx_q <= acx_d;
      acy_q <= acy_d;
    end
  end

  // ---- stage 2: squares and cross products --------------------------------
  logic signed [PR-1:0] sqx_full [3];
  logic signed [PR-1:0] sqy_full [3];
  logic [SQ-1:0]        sqx_q [3];
  logic [SQ-1:0]        sqy_q [3];
  logic signed [PR-1:0] p1_d, p2_d, p1_q, p2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqx_full[i] = dx_q[i] * dx_q[i];
      sqy_full[i] = dy_q[i] * dy_q[i];
    end
    // (bx-ax)*(cy-ay) and (cx-ax)*(by-ay)
    p1_d = dx_q[0] * acy_q;
    p2_d = acx_q * dy_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqx_q[i] <= sqx_full[i][SQ-1:0];
        sqy_q[i] <= sqy_full[i][SQ-1:0];
      end
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
  end

  // ---- stage 3: length sums and cross sum ---------------------------------
  logic [SQ:0]          sum_full [3];
  logic [SQ-1:0]        sum_q [3];
  logic signed [CR-1:0] cross_d, cross_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_full[i] = {1'b0, sqx_q[i]} + {1'b0, sqy_q[i]};
    end
    cross_d = {p1_q[PR-1], p1_q} - {p2_q[PR-1], p2_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= sum_full[i][SQ-1:0];
      end
      cross_q <= cross_d;
    end
  end

  // ---- square root stages, cross sum delayed alongside --------------------
  logic [RT-1:0]        root [3];
  logic signed [CR-1:0] cr_dly_q [RT];

  for (genvar e = 0; e < 3; e++) begin : g_edge
    tap_isqrt_pipe #(
      .COORD_BITS (COORD_BITS)
    ) u_isqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (sum_q[e]),
      .root_o (root[e])
    );
  end

  for (genvar j = 0; j < RT; j++) begin : g_cr_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        cr_dly_q[j] <= (j == 0) ? cross_q : cr_dly_q[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // ---- final stage: perimeter add and area magnitude ----------------------
  logic [CR-1:0] mag;
  logic [PW-1:0] perim_d, perim_q;
  logic [AW-1:0] area_d, area_q;

  always_comb begin
    mag     = cr_dly_q[RT-1][CR-1] ? CR'(-cr_dly_q[RT-1]) : CR'(cr_dly_q[RT-1]);
    // halving the magnitude truncates toward zero
    area_d  = mag[AW:1];
    perim_d = {2'b00, root[0]} + {2'b00, root[1]} + {2'b00, root[2]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      area_q  <= area_d;
      perim_q <= perim_d;
    end
  end

  // ---- valid bits ---------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], in_xfer};
    end
  end

  // ---- output skid stage --------------------------------------------------
  // holds the last result when the receiver stalls while the pipeline moves
  assign res_data = OUT_W'({perim_q, area_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (m_axis_tready_i) begin
        skid_vld_q <= 1'b0;
      end
    end else if (vld_q[L-1] && !m_axis_tready_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q && vld_q[L-1] && !m_axis_tready_i) begin
      skid_q <= res_data;
    end
  end

  assign m_axis_tvalid_o = skid_vld_q || vld_q[L-1];
  assign m_axis_tdata_o  = skid_vld_q ? skid_q : res_data;

`ifndef ASSERT_OFF
  // a full skid register freezes the pipeline
  a_skid_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |=> $stable(vld_q))
    else $error("pipeline moved while skid register full");

  // a held result stays until the receiver takes it
  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !m_axis_tready_i |=> skid_vld_q)
    else $error("skid register dropped an untaken result");

  // a stalled result leaving the pipeline is caught
  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[L-1] && !m_axis_tready_i && !skid_vld_q |=> skid_vld_q)
    else $error("stalled result not caught in skid register");

  // input is refused only while a result is waiting
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input refused with no result pending");
`endif

endmodule

// File: dv/tb_triangle_area_perimeter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_area_perimeter
// self-checking bench for the triangle area and perimeter unit
// ----------------------------------------------------------------------------
// a short table of hand-picked triangles (zero, unit, odd cross sums, both
// vertex orders, the corners of the coordinate range, collinear and
// coincident vertices) is followed by 430 random triangles. every transfer
// on s_axis pushes its expected area and perimeter, typed in or worked out
// by an exact integer model in this file, and every transfer on m_axis is
// compared field by field with the oldest expectation. both sides idle in
// short random bursts; the receiver holds off once for a long stretch and
// the sender waits for the pipeline to empty after the table and mid-run.
// ----------------------------------------------------------------------------
module tb_triangle_area_perimeter;

  localparam int CW         = tap_pkg::CoordBitsDef;
  localparam int AW         = 2 * CW + 1;               // area width
  localparam int PW         = CW + 3;                   // perimeter width
  localparam int InW        = ((6 * CW + 7) / 8) * 8;
  localparam int OutW       = ((3 * CW + 4 + 7) / 8) * 8;
  localparam int Latency    = CW + 5;
  localparam int RandItems  = 430;
  localparam int DrainAt    = 300;                      // sender pause point
  localparam int TailItems  = 60;                       // no idling at the end
  localparam int LongHold   = 80;                       // receiver hold-off, cycles
  localparam int HoldAfter  = 150;                      // results before the hold
  localparam int StallLimit = 2000;
  localparam int ShowErrors = 10;

  // one triangle, vertices a, b, c
  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } triangle_t;

  typedef struct packed {
    logic [AW-1:0] area;
    logic [PW-1:0] perim;
  } measure_t;

  typedef struct packed {
    triangle_t tri_in;
    logic      typed;     // expectation typed into the table
    measure_t  want;
  } table_row_t;

  logic            clk_i;
  logic            rst_ni   = 1'b0;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [InW-1:0]  s_tdata  = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [OutW-1:0] m_tdata;

  measure_t   awaited_q[$];      // expected results, oldest first
  table_row_t directed_q[$];
  bit         quiet_tail      = 1'b0;
  int         triangles_sent  = 0;
  int         results_checked = 0;
  int         flat_triangles  = 0;
  int         error_count     = 0;
  int         idle_cycles     = 0;
  int         peak_in_flight  = 0;
  bit         hold_done       = 1'b0;

  triangle_area_perimeter DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // exact integer model
  // --------------------------------------------------------------------------

  // bit-by-bit floor square root
  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = n;
    root  = 0;
    probe = 64'h1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned side_length(input longint x0, input longint y0,
                                                  input longint x1, input longint y1);
    longint dx;
    longint dy;
    dx = x0 - x1;
    dy = y0 - y1;
    return floor_sqrt(longint'(dx * dx + dy * dy));
  endfunction

  function automatic measure_t triangle_measure(input triangle_t t);
    longint   ax, ay, bx, by, cx, cy;
    longint   cross_sum;
    measure_t m;
    ax        = t.ax;
    ay        = t.ay;
    bx        = t.bx;
    by        = t.by;
    cx        = t.cx;
    cy        = t.cy;
    cross_sum = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
    // halving after the absolute value truncates towards zero
    if (cross_sum < 0) cross_sum = -cross_sum;
    m.area  = AW'(cross_sum >> 1);
    m.perim = PW'(side_length(ax, ay, bx, by) + side_length(bx, by, cx, cy)
                  + side_length(cx, cy, ax, ay));
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  function automatic triangle_t make_triangle(input int ax, input int ay, input int bx,
                                              input int by, input int cx, input int cy);
    triangle_t t;
    t.ax = CW'(ax);
    t.ay = CW'(ay);
    t.bx = CW'(bx);
    t.by = CW'(by);
    t.cx = CW'(cx);
    t.cy = CW'(cy);
    return t;
  endfunction

  // table row; area and perimeter only count when typed is set
  task automatic add_row(input triangle_t t, input bit typed, input longint area,
                         input longint perim);
    table_row_t r;
    r.tri_in     = t;
    r.typed      = typed;
    r.want.area  = AW'(area);
    r.want.perim = PW'(perim);
    directed_q.push_back(r);
  endtask

  function automatic int corner_coord();
    int corners[8];
    corners = '{-32768, -32767, -256, -1, 0, 1, 32766, 32767};
    return corners[$urandom_range(0, 7)];
  endfunction

  function automatic triangle_t random_triangle();
    triangle_t t;
    int        mode, px, py, dx, dy, k;
    mode = $urandom_range(0, 9);
    px   = $urandom_range(0, 65535);
    py   = $urandom_range(0, 65535);
    case (mode)
      0, 1, 2, 3: begin
        // anywhere in the coordinate range
        t = make_triangle(px, py, $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535));
      end
      4, 5, 6: begin
        // small triangle around a random point, may wrap at the range edge
        t = make_triangle(px + $urandom_range(0, 1023) - 512, py + $urandom_range(0, 1023) - 512,
                          px + $urandom_range(0, 1023) - 512, py + $urandom_range(0, 1023) - 512,
                          px + $urandom_range(0, 1023) - 512, py + $urandom_range(0, 1023) - 512);
      end
      7: begin
        t = make_triangle(corner_coord(), corner_coord(), corner_coord(),
                          corner_coord(), corner_coord(), corner_coord());
      end
      8: begin
        // collinear unless the step wraps
        dx = $urandom_range(0, 4095) - 2048;
        dy = $urandom_range(0, 4095) - 2048;
        k  = $urandom_range(0, 6) - 3;
        t  = make_triangle(px, py, px + dx, py + dy, px + k * dx, py + k * dy);
      end
      default: begin
        // two vertices on top of each other
        t = make_triangle(px, py, px, py, $urandom_range(0, 65535), $urandom_range(0, 65535));
      end
    endcase
    return t;
  endfunction

  // offer one triangle and wait for its transfer
  task automatic send_triangle(input triangle_t t, input measure_t want);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= InW'({t.cy, t.cx, t.by, t.bx, t.ay, t.ax});
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    awaited_q.push_back(want);
    triangles_sent++;
    if (awaited_q.size() > peak_in_flight) peak_in_flight = awaited_q.size();
  endtask

  // stop offering until every result has come back
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaited_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    measure_t want;
    triangle_t t;

    // zero, unit triangles and odd cross sums
    add_row(make_triangle(0, 0, 0, 0, 0, 0), 1'b1, 0, 0);
    add_row(make_triangle(0, 0, 1, 0, 0, 1), 1'b1, 0, 3);
    add_row(make_triangle(0, 0, 0, 1, 1, 0), 1'b1, 0, 3);
    add_row(make_triangle(0, 0, 3, 0, 0, 1), 1'b1, 1, 7);
    // 3-4-5 triangle in q8.8, both vertex orders, then a right isosceles one
    add_row(make_triangle(0, 0, 768, 0, 0, 1024), 1'b1, 393216, 3072);
    add_row(make_triangle(0, 0, 0, 1024, 768, 0), 1'b1, 393216, 3072);
    add_row(make_triangle(-1, -1, -1, -257, -257, -1), 1'b1, 32768, 874);
    // coincident vertices at the range corners
    add_row(make_triangle(32767, 32767, 32767, 32767, 32767, 32767), 1'b1, 0, 0);
    add_row(make_triangle(-32768, -32768, -32768, -32768, -32768, -32768), 1'b1, 0, 0);
    // largest triangles, both orders and both halves of the square
    add_row(make_triangle(-32768, -32768, 32767, -32768, -32768, 32767), 1'b0, 0, 0);
    add_row(make_triangle(-32768, -32768, -32768, 32767, 32767, -32768), 1'b0, 0, 0);
    add_row(make_triangle(32767, 32767, -32768, 32767, 32767, -32768), 1'b0, 0, 0);
    add_row(make_triangle(-32768, -32768, 32767, 32767, -32768, 32767), 1'b0, 0, 0);
    add_row(make_triangle(-32768, 0, 32767, 0, 0, 32767), 1'b0, 0, 0);
    add_row(make_triangle(-32768, 32767, 32767, -32768, -1, 0), 1'b0, 0, 0);
    // collinear and partly coincident
    add_row(make_triangle(0, 0, 256, 256, 512, 512), 1'b0, 0, 0);
    add_row(make_triangle(-32768, -32768, 0, 0, 32767, 32767), 1'b0, 0, 0);
    add_row(make_triangle(100, -100, 100, -100, -5000, 7000), 1'b0, 0, 0);
    // alternating bit patterns
    add_row(make_triangle(21845, -21846, -21846, 21845, 0, -1), 1'b0, 0, 0);
    add_row(make_triangle(-1, 21845, 21845, -1, -21846, -21846), 1'b0, 0, 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) begin
      want = directed_q[i].typed ? directed_q[i].want : triangle_measure(directed_q[i].tri_in);
      send_triangle(directed_q[i].tri_in, want);
    end
    wait_for_drain();

    for (int i = 0; i < RandItems; i++) begin
      if (i == DrainAt) wait_for_drain();
      if (i == RandItems - TailItems) quiet_tail = 1'b1;
      t = random_triangle();
      send_triangle(t, triangle_measure(t));
    end
    wait_for_drain();
    repeat (2 * Latency) @(posedge clk_i);

    $display("run: %0d triangles (%0d from the table), %0d results checked, %0d with zero area",
             triangles_sent, directed_q.size(), results_checked, flat_triangles);
    $display("run: up to %0d results in flight, long receiver hold-off %0s, %0d mismatches",
             peak_in_flight, hold_done ? "done" : "missed", error_count);
    if (error_count == 0) begin
      $display("** triangle_area_perimeter: PASSED **");
    end else begin
      $display("** triangle_area_perimeter: FAILED **");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver: short random stalls, one long hold-off, none in the tail
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && results_checked >= HoldAfter) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        gap = $urandom_range(1, 4);
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // result check, values sampled before the edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    measure_t got;
    measure_t want;
    got.area  = m_tdata[AW-1:0];
    got.perim = m_tdata[AW+PW-1:AW];
    if (rst_ni && m_tvalid && m_tready) begin
      results_checked++;
      if (awaited_q.size() == 0) begin
        error_count++;
        if (error_count <= ShowErrors)
          $display("%0t: unexpected result area %0d perimeter %0d", $realtime,
                   got.area, got.perim);
      end else begin
        want = awaited_q.pop_front();
        if (want.area == 0) flat_triangles++;
        if (got.area !== want.area) begin
          error_count++;
          if (error_count <= ShowErrors)
            $display("%0t: result %0d area expected %0d got %0d", $realtime,
                     results_checked, want.area, got.area);
        end
        if (got.perim !== want.perim) begin
          error_count++;
          if (error_count <= ShowErrors)
            $display("%0t: result %0d perimeter expected %0d got %0d", $realtime,
                     results_checked, want.perim, got.perim);
        end
      end
    end
  end

  // watchdog: cycles without any transfer on either side
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $realtime,
                 StallLimit, awaited_q.size());
        $display("** triangle_area_perimeter: FAILED **");
        $finish;
      end
    end
  end

endmodule

// File: sim.f
sv/tap_pkg.sv
sv/tap_isqrt_pipe.sv
sv/triangle_area_perimeter.sv
dv/tb_triangle_area_perimeter.sv
